// File: hw/rtl/bc7rtc_pkg.sv
// Shared types and constants for the seven-bit bank controller.
`timescale 1ns / 1ps
`default_nettype none

package bc7rtc_pkg;

	// Result target codes
	typedef logic [1:0] target_t;
	localparam target_t TGT_NONE  = 2'd0;
	localparam target_t TGT_ROM   = 2'd1;
	localparam target_t TGT_RAM   = 2'd2;
	localparam target_t TGT_FIXED = 2'd3;

	// Access kinds carried in tuser
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// Defaults for the top-level parameters
	localparam int RAM_BANK_COUNT_DEF = 4;
	localparam int ROM_BANK_BITS_DEF  = 7;

	// Field widths
	localparam int ADDR_W     = 16;
	localparam int DATA_W     = 8;
	localparam int ROM_ADDR_W = 21;
	localparam int RAM_OFS_W  = 13;
	localparam int RAM_BANK_SIZE = 8192;

	// Fixed read values and control codes
	localparam logic [7:0] FIXED_DISABLED = 8'hFF;
	localparam logic [7:0] FIXED_CLOCK    = 8'h00;
	localparam logic [3:0] ENABLE_CODE    = 4'hA;
	localparam logic [7:0] RAM_BANK_MAX   = 8'h03;
	localparam logic [7:0] CLOCK_SEL_LO   = 8'h08;
	localparam logic [7:0] CLOCK_SEL_HI   = 8'h0C;

	// Bus windows, by the top address bits
	localparam logic [2:0] WIN_RAM = 3'b101;

endpackage

`default_nettype wire

// File: hw/rtl/bank_controller_seven_bit_rtc_top.sv
// Top level of the seven-bit bank controller: bus decode, control registers and banked RAM.
//
//   channel  | dir | handshake                      | payload
//   ---------+-----+--------------------------------+-------------------------------------------
//   s_axis   | in  | s_axis_tvalid / s_axis_tready  | tdata: bus_address, write_data; tuser: opcode
//   m_axis   | out | m_axis_tvalid / m_axis_tready  | tdata: rom_address, read_data; tuser: target
//
// One access is taken per cycle while s_axis_tready is high; its result passes through the
// decode stage (decode and RAM read), then the output register.
// The single-port RAM is written or read at the accepting edge, so back-to-back
// accesses to the same byte need no forwarding.
// After reset a clearing pass zeroes the RAM, one byte a cycle, over all
// RAM_BANK_COUNT * 8192 bytes; s_axis_tready stays low during the pass.
// A stall on m_axis holds the output register and the decode stage; outside the clearing pass,
// input is taken whenever the decode stage is empty or moves on in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module bank_controller_seven_bit_rtc_top #(
	parameter int RAM_BANK_COUNT = bc7rtc_pkg::RAM_BANK_COUNT_DEF,
	parameter int ROM_BANK_BITS  = bc7rtc_pkg::ROM_BANK_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,   // [15:0] bus_address, [23:16] write_data
	input  wire logic [0:0]  s_axis_tuser,   // [0] opcode
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,   // [20:0] rom_address, [28:21] read_data,
	                                         // [31:29] zero
	output logic [1:0]       m_axis_tuser    // [1:0] target
);

	localparam int RAM_DEPTH = RAM_BANK_COUNT * bc7rtc_pkg::RAM_BANK_SIZE;
	localparam int RAM_AW    = $clog2(RAM_DEPTH);

	// Control registers
	logic [ROM_BANK_BITS-1:0] rom_bank_q;
	logic [1:0]               ram_bank_q;
	logic                     enable_q;
	logic                     clk_map_q;

	// Clearing pass
	logic              clearing_q;
	logic [RAM_AW-1:0] clr_cnt_q;

	// Decode stage
	logic                                   valid_s1;
	bc7rtc_pkg::target_t                    target_s1;
	logic [bc7rtc_pkg::ROM_ADDR_W-1:0]      rom_s1;
	logic [bc7rtc_pkg::DATA_W-1:0]          fixed_s1;
	logic                                   use_ram_s1;

	// Output register
	logic                out_valid_q;
	logic [31:0]         out_data_q;
	bc7rtc_pkg::target_t out_target_q;

	// Banked RAM
	logic [bc7rtc_pkg::DATA_W-1:0] ram_mem [RAM_DEPTH];
	logic [bc7rtc_pkg::DATA_W-1:0] ram_rd_q;

	// Input fields
	logic [bc7rtc_pkg::ADDR_W-1:0] addr;
	logic [bc7rtc_pkg::DATA_W-1:0] wdat;
	logic                          is_wr;
	logic                          in_ram_win;

	logic accept;
	logic adv_s1;

	// Decode results
	bc7rtc_pkg::target_t               dec_target;
	logic [bc7rtc_pkg::ROM_ADDR_W-1:0] dec_rom;
	logic [bc7rtc_pkg::DATA_W-1:0]     dec_fixed;
	logic                              dec_use_ram;
	logic                              ram_we;
	logic                              ram_re;

	// RAM addressing
	logic [1:0]                           bank_red;
	logic [bc7rtc_pkg::RAM_OFS_W+1:0]     ram_idx_full;
	logic [RAM_AW-1:0]                    ram_addr;

	logic [bc7rtc_pkg::DATA_W-1:0] out_rd;

	assign addr       = s_axis_tdata[15:0];
	assign wdat       = s_axis_tdata[23:16];
	assign is_wr      = (s_axis_tuser[0] == bc7rtc_pkg::OP_WRITE);
	assign in_ram_win = (addr[15:13] == bc7rtc_pkg::WIN_RAM);

	assign adv_s1        = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !clearing_q && (!valid_s1 || adv_s1);
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Fold the RAM bank into the bank count (three compare-subtract steps on two bits)
	always_comb begin
		bank_red = ram_bank_q;
		for (int i = 0; i < 3; i++) begin
			if (int'(bank_red) >= RAM_BANK_COUNT) begin
				bank_red = bank_red - 2'(RAM_BANK_COUNT);
			end
		end
	end

	assign ram_idx_full = {bank_red, addr[bc7rtc_pkg::RAM_OFS_W-1:0]};
	assign ram_addr     = ram_idx_full[RAM_AW-1:0];

	// Decode the access
	always_comb begin
		dec_target  = bc7rtc_pkg::TGT_NONE;
		dec_rom     = '0;
		dec_fixed   = '0;
		dec_use_ram = 1'b0;
		ram_we      = 1'b0;
		ram_re      = 1'b0;
		if (!is_wr) begin
			if (addr[15:14] == 2'b00) begin
				dec_target = bc7rtc_pkg::TGT_ROM;
				dec_rom    = bc7rtc_pkg::ROM_ADDR_W'(addr);
			end else if (addr[15:14] == 2'b01) begin
				// switchable bank: bank number above the 14-bit offset
				dec_target = bc7rtc_pkg::TGT_ROM;
				dec_rom    = bc7rtc_pkg::ROM_ADDR_W'({rom_bank_q, addr[13:0]});
			end else if (in_ram_win) begin
				if (!enable_q) begin
					dec_target = bc7rtc_pkg::TGT_FIXED;
					dec_fixed  = bc7rtc_pkg::FIXED_DISABLED;
				end else if (clk_map_q) begin
					dec_target = bc7rtc_pkg::TGT_FIXED;
					dec_fixed  = bc7rtc_pkg::FIXED_CLOCK;
				end else begin
					dec_target  = bc7rtc_pkg::TGT_RAM;
					dec_use_ram = 1'b1;
					ram_re      = accept;
				end
			end
		end else if (in_ram_win && enable_q && !clk_map_q) begin
			dec_target = bc7rtc_pkg::TGT_RAM;
			ram_we     = accept;
		end
	end

	// Control register writes take effect at the transfer edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_bank_q <= ROM_BANK_BITS'(1);
			ram_bank_q <= '0;
			enable_q   <= 1'b0;
			clk_map_q  <= 1'b0;
		end else if (accept && is_wr) begin
			unique case (addr[15:13])
				3'b000: enable_q <= (wdat[3:0] == bc7rtc_pkg::ENABLE_CODE);
				3'b001: begin
					// bank zero maps to bank one
					if (wdat[ROM_BANK_BITS-1:0] == '0) begin
						rom_bank_q <= ROM_BANK_BITS'(1);
					end else begin
						rom_bank_q <= wdat[ROM_BANK_BITS-1:0];
					end
				end
				3'b010: begin
					if (wdat <= bc7rtc_pkg::RAM_BANK_MAX) begin
						ram_bank_q <= wdat[1:0];
						clk_map_q  <= 1'b0;
					end else if (wdat >= bc7rtc_pkg::CLOCK_SEL_LO &&
					             wdat <= bc7rtc_pkg::CLOCK_SEL_HI) begin
						clk_map_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == RAM_AW'(RAM_DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// Single-port RAM: one write or one registered read a cycle
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			ram_mem[clr_cnt_q] <= '0;
		end else if (ram_we) begin
			ram_mem[ram_addr] <= wdat;
		end
		if (ram_re) begin
			ram_rd_q <= ram_mem[ram_addr];
		end
	end

	// Decode stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Decode stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			target_s1  <= dec_target;
			rom_s1     <= dec_rom;
			fixed_s1   <= dec_fixed;
			use_ram_s1 <= dec_use_ram;
		end
	end

	assign out_rd = use_ram_s1 ? ram_rd_q : fixed_s1;

	// Output register: hold while stalled, load when the decode stage moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_data_q   <= {3'b000, out_rd, rom_s1};
			out_target_q <= target_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_target_q;

endmodule

`default_nettype wire

// File: hw/rtl/bc7rtc_checker.sv
// Port-level checker for the seven-bit bank controller, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bc7rtc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [23:0] s_axis_tdata,
	input wire logic [0:0]  s_axis_tuser,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [31:0] m_axis_tdata,
	input wire logic [1:0]  m_axis_tuser
);

	logic [1:0] pend_q;
	logic       in_xfer;
	logic       out_xfer;

	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign out_xfer = m_axis_tvalid && m_axis_tready;

	// Track accesses taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_xfer && !out_xfer) begin
			pend_q <= pend_q + 1'b1;
		end else if (out_xfer && !in_xfer) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
		$stable(m_axis_tuser))
		else $error("result changed while stalled");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> pend_q != 2'd0)
		else $error("result shown without a pending access");

	a_two_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more accesses in flight than stages");

	a_rom_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == bc7rtc_pkg::TGT_ROM ||
		                  m_axis_tuser == bc7rtc_pkg::TGT_NONE)
		|-> m_axis_tdata[28:21] == 8'h00)
		else $error("read data set on a ROM or empty result");

	a_rom_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != bc7rtc_pkg::TGT_ROM
		|-> m_axis_tdata[20:0] == 21'd0)
		else $error("ROM address set on a non-ROM result");

endmodule

bind bank_controller_seven_bit_rtc_top bc7rtc_checker u_bc7rtc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// File: bench/tb_bank_controller_seven_bit_rtc_top.sv
// Self-checking testbench for the seven-bit bank controller: directed and random bus traffic with stalls.
`timescale 1ns / 1ps

module tb_bank_controller_seven_bit_rtc_top;

	localparam int BANK_COUNT   = 4;
	localparam int ROM_BITS     = 7;
	// Least total of accesses, directed ones included.
	localparam int RANDOM_ITEMS = 450;
	// The last stretch of the stimulus runs with both sides streaming at full rate.
	localparam int TAIL_ITEMS   = 60;
	localparam int DRAIN_CYCLES = 8;
	localparam int SHADOW_DEPTH = BANK_COUNT * bc7rtc_pkg::RAM_BANK_SIZE;

	typedef struct packed {
		logic        op;
		logic [15:0] addr;
		logic [7:0]  data;
	} bus_access_t;

	typedef struct packed {
		bc7rtc_pkg::target_t target;
		logic [20:0]         rom_addr;
		logic [7:0]          rd_data;
	} bus_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic [0:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;

	bank_controller_seven_bit_rtc_top #(
		.RAM_BANK_COUNT(BANK_COUNT),
		.ROM_BANK_BITS (ROM_BITS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	// Shadow of the mapper state, advanced once per accepted access.
	logic [6:0] rom_bank_sel = 7'd1;
	logic [1:0] ram_bank_sel = 2'd0;
	logic       ram_enabled  = 1'b0;
	logic       clock_on     = 1'b0;
	logic [7:0] ram_shadow [0:SHADOW_DEPTH-1];

	bus_access_t access_q [$];   // accesses waiting to be sent
	bus_result_t result_q [$];   // predicted results, oldest first

	bus_access_t taken_access;
	logic        taken = 1'b0;      // set at the accepting edge, consumed at the next falling edge
	logic        in_flight = 1'b0;  // tvalid is up and the transfer has not happened yet
	logic        quiet = 1'b0;      // stretch with no idling on either side
	int          src_gap = 0;
	int          sink_gap = 0;
	int          errors = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("tb_bank_controller_seven_bit_rtc_top NOT OK");
		$finish;
	end

	// Work out the result of one access and update the shadow state.
	function automatic bus_result_t decode_access(bus_access_t a);
		bus_result_t r;
		logic [14:0] ram_idx;
		logic [6:0]  bank;
		r = '0;
		r.target = bc7rtc_pkg::TGT_NONE;
		ram_idx = 15'((bc7rtc_pkg::RAM_BANK_SIZE * (ram_bank_sel % BANK_COUNT)) +
			a.addr[bc7rtc_pkg::RAM_OFS_W-1:0]);
		if (a.op == bc7rtc_pkg::OP_READ) begin
			if (a.addr <= 16'h3FFF) begin
				r.target = bc7rtc_pkg::TGT_ROM;
				r.rom_addr = {5'd0, a.addr};
			end else if (a.addr <= 16'h7FFF) begin
				// switchable window: bank number on top of the 14-bit offset
				r.target = bc7rtc_pkg::TGT_ROM;
				r.rom_addr = {rom_bank_sel, a.addr[13:0]};
			end else if (a.addr[15:13] == bc7rtc_pkg::WIN_RAM) begin
				if (!ram_enabled) begin
					r.target = bc7rtc_pkg::TGT_FIXED;
					r.rd_data = bc7rtc_pkg::FIXED_DISABLED;
				end else if (clock_on) begin
					r.target = bc7rtc_pkg::TGT_FIXED;
					r.rd_data = bc7rtc_pkg::FIXED_CLOCK;
				end else begin
					r.target = bc7rtc_pkg::TGT_RAM;
					r.rd_data = ram_shadow[ram_idx];
				end
			end
		end else begin
			if (a.addr <= 16'h1FFF) begin
				ram_enabled = (a.data[3:0] == bc7rtc_pkg::ENABLE_CODE);
			end else if (a.addr <= 16'h3FFF) begin
				bank = a.data[6:0] & 7'((1 << ROM_BITS) - 1);
				rom_bank_sel = (bank == 7'd0) ? 7'd1 : bank;
			end else if (a.addr <= 16'h5FFF) begin
				if (a.data <= bc7rtc_pkg::RAM_BANK_MAX) begin
					ram_bank_sel = a.data[1:0];
					clock_on = 1'b0;
				end else if (a.data >= bc7rtc_pkg::CLOCK_SEL_LO &&
				             a.data <= bc7rtc_pkg::CLOCK_SEL_HI) begin
					clock_on = 1'b1;
				end
			end else if (a.addr[15:13] == bc7rtc_pkg::WIN_RAM) begin
				if (ram_enabled && !clock_on) begin
					ram_shadow[ram_idx] = a.data;
					r.target = bc7rtc_pkg::TGT_RAM;
				end
			end
		end
		return r;
	endfunction

	task automatic queue_access(input logic op, input logic [15:0] addr, input logic [7:0] data);
		bus_access_t a;
		a.op = op;
		a.addr = addr;
		a.data = data;
		access_q.push_back(a);
	endtask

	function automatic logic idling_allowed();
		return !quiet && access_q.size() > TAIL_ITEMS;
	endfunction

	// Driver: note transfers at the rising edge, present the next access at the falling edge.
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			taken_access.op   = s_axis_tuser[0];
			taken_access.addr = s_axis_tdata[15:0];
			taken_access.data = s_axis_tdata[23:16];
			taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (taken) begin
			taken = 1'b0;
			in_flight = 1'b0;
			result_q.push_back(decode_access(taken_access));
			access_q.delete(0);
			if ($urandom_range(0, 39) == 0)
				quiet = !quiet;
			if (idling_allowed() && $urandom_range(0, 5) == 0)
				src_gap = $urandom_range(1, 14);
		end
		if (arst_n && !in_flight) begin
			if (src_gap != 0) begin
				src_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (access_q.size() != 0) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= {access_q[0].data, access_q[0].addr};
				s_axis_tuser  <= access_q[0].op;
				in_flight = 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Monitor: throttle tready in bursts, check every result transfer against the oldest prediction.
	always @(negedge clk) begin
		if (arst_n) begin
			if (sink_gap != 0) begin
				sink_gap--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (idling_allowed() && $urandom_range(0, 7) == 0)
					sink_gap = $urandom_range(1, 14);
			end
		end
	end

	always @(posedge clk) begin
		bus_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (result_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h %h",
					$time, m_axis_tuser, m_axis_tdata);
				errors++;
			end else begin
				want = result_q.pop_front();
				if (m_axis_tuser !== want.target) begin
					$display("%0t: target expected %0d actual %0d",
						$time, want.target, m_axis_tuser);
					errors++;
				end
				if (m_axis_tdata[20:0] !== want.rom_addr) begin
					$display("%0t: rom_address expected %h actual %h",
						$time, want.rom_addr, m_axis_tdata[20:0]);
					errors++;
				end
				if (m_axis_tdata[28:21] !== want.rd_data) begin
					$display("%0t: read_data expected %h actual %h",
						$time, want.rd_data, m_axis_tdata[28:21]);
					errors++;
				end
			end
		end
	end

	initial begin
		int          steps;
		logic [12:0] hot_ofs [0:7];
		logic [12:0] ofs;
		logic [3:0]  nib;
		int          slot;

		for (int i = 0; i < SHADOW_DEPTH; i++)
			ram_shadow[i] = 8'h00;
		for (int i = 0; i < 8; i++)
			hot_ofs[i] = 13'($urandom_range(0, 13'h1FFF));

		// Directed: window edges, bank register corner values, enable and clock mapping.
		queue_access(bc7rtc_pkg::OP_READ,  16'h0000, 8'h00);
		queue_access(bc7rtc_pkg::OP_READ,  16'h3FFF, 8'hFF);
		queue_access(bc7rtc_pkg::OP_READ,  16'h4000, 8'h00);   // default bank 1
		queue_access(bc7rtc_pkg::OP_READ,  16'hA000, 8'h00);   // RAM disabled reads FF
		queue_access(bc7rtc_pkg::OP_READ,  16'h8000, 8'h00);   // unmapped
		queue_access(bc7rtc_pkg::OP_READ,  16'hFFFF, 8'hFF);   // unmapped
		queue_access(bc7rtc_pkg::OP_WRITE, 16'h3FFF, 8'hFF);   // bank 7F
		queue_access(bc7rtc_pkg::OP_READ,  16'h7FFF, 8'h00);
		queue_access(bc7rtc_pkg::OP_WRITE, 16'h2000, 8'h80);   // masks to zero, becomes bank 1
		queue_access(bc7rtc_pkg::OP_READ,  16'h5000, 8'h00);
		queue_access(bc7rtc_pkg::OP_WRITE, 16'h0000, 8'h0A);   // enable
		queue_access(bc7rtc_pkg::OP_WRITE, 16'hA000, 8'h5A);
		queue_access(bc7rtc_pkg::OP_READ,  16'hA000, 8'h00);
		queue_access(bc7rtc_pkg::OP_WRITE, 16'h4000, 8'h03);   // top RAM bank
		queue_access(bc7rtc_pkg::OP_WRITE, 16'hBFFF, 8'hFF);
		queue_access(bc7rtc_pkg::OP_READ,  16'hBFFF, 8'h00);
		queue_access(bc7rtc_pkg::OP_WRITE, 16'h5FFF, 8'h08);   // map the clock
		queue_access(bc7rtc_pkg::OP_READ,  16'hA000, 8'h00);   // clock mapped reads 00
		queue_access(bc7rtc_pkg::OP_WRITE, 16'hA000, 8'h11);   // dropped while the clock is mapped
		queue_access(bc7rtc_pkg::OP_WRITE, 16'h4000, 8'h0D);   // outside both ranges, ignored
		queue_access(bc7rtc_pkg::OP_WRITE, 16'h4000, 8'h00);   // bank 0 and unmap the clock
		queue_access(bc7rtc_pkg::OP_READ,  16'hA000, 8'h00);
		queue_access(bc7rtc_pkg::OP_WRITE, 16'h6000, 8'h01);   // 6000-7FFF write, ignored
		queue_access(bc7rtc_pkg::OP_WRITE, 16'h1FFF, 8'hFB);   // low nibble not A disables
		queue_access(bc7rtc_pkg::OP_WRITE, 16'hA001, 8'h33);   // dropped while disabled
		queue_access(bc7rtc_pkg::OP_WRITE, 16'hC000, 8'h44);   // unmapped write

		// Random: mostly enable/select/RAM sessions, some ROM traffic, some raw noise.
		while (access_q.size() < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					queue_access(bc7rtc_pkg::OP_WRITE, 16'($urandom_range(0, 16'h1FFF)),
						{4'($urandom_range(0, 15)), bc7rtc_pkg::ENABLE_CODE});
					if ($urandom_range(0, 3) != 0)
						queue_access(bc7rtc_pkg::OP_WRITE,
							16'(16'h4000 + $urandom_range(0, 16'h1FFF)),
							8'($urandom_range(0, bc7rtc_pkg::RAM_BANK_MAX)));
					steps = $urandom_range(2, 8);
					repeat (steps) begin
						slot = $urandom_range(0, 7);
						if ($urandom_range(0, 3) == 0)
							hot_ofs[slot] = 13'($urandom_range(0, 13'h1FFF));
						ofs = hot_ofs[slot];
						case ($urandom_range(0, 7))
							0, 1, 2: queue_access(bc7rtc_pkg::OP_WRITE,
								{bc7rtc_pkg::WIN_RAM, ofs}, 8'($urandom_range(0, 255)));
							3, 4, 5: queue_access(bc7rtc_pkg::OP_READ,
								{bc7rtc_pkg::WIN_RAM, ofs}, 8'($urandom_range(0, 255)));
							6: queue_access(bc7rtc_pkg::OP_WRITE,
								16'(16'h4000 + $urandom_range(0, 16'h1FFF)),
								8'($urandom_range(0, 15)));
							default: begin
								queue_access(bc7rtc_pkg::OP_WRITE,
									16'(16'h2000 + $urandom_range(0, 16'h1FFF)),
									8'($urandom_range(0, 255)));
								queue_access(bc7rtc_pkg::OP_READ,
									16'($urandom_range(0, 16'h7FFF)),
									8'($urandom_range(0, 255)));
							end
						endcase
					end
					if ($urandom_range(0, 2) == 0) begin
						nib = 4'($urandom_range(0, 14));
						if (nib >= bc7rtc_pkg::ENABLE_CODE)
							nib++;
						queue_access(bc7rtc_pkg::OP_WRITE, 16'($urandom_range(0, 16'h1FFF)),
							{4'($urandom_range(0, 15)), nib});
					end
				end
				6, 7: begin
					queue_access(bc7rtc_pkg::OP_WRITE,
						16'(16'h2000 + $urandom_range(0, 16'h1FFF)),
						8'($urandom_range(0, 255)));
					steps = $urandom_range(2, 5);
					repeat (steps)
						queue_access(bc7rtc_pkg::OP_READ, 16'($urandom_range(0, 16'h7FFF)),
							8'($urandom_range(0, 255)));
				end
				default: begin
					steps = $urandom_range(1, 4);
					repeat (steps)
						queue_access(1'($urandom_range(0, 1)),
							16'($urandom_range(0, 16'hFFFF)),
							8'($urandom_range(0, 255)));
				end
			endcase
		end

		// Hold reset low, then release it at a falling edge, away from the rising edge.
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// The clearing pass keeps tready low for a while; the timeout covers it.
		while (access_q.size() != 0 || in_flight || taken || result_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("tb_bank_controller_seven_bit_rtc_top OK");
		else
			$display("tb_bank_controller_seven_bit_rtc_top NOT OK");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/bc7rtc_pkg.sv
hw/rtl/bank_controller_seven_bit_rtc_top.sv
hw/rtl/bc7rtc_checker.sv
bench/tb_bank_controller_seven_bit_rtc_top.sv
